/* hw/rtl/dsd_pkg.sv */
// shared constants, types and month table for the date span day counter
package dsd_pkg;

  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int SPAN_W  = 23;
  localparam int Q100_W  = 7;
  localparam int DBM_W   = 9;

  localparam logic [YEAR_W-1:0]  MAX_YEAR    = 14'd9999;
  localparam logic [FIELD_W-1:0] FIELD_LIMIT = 7'd99;
  localparam logic [FIELD_W-1:0] MONTH_FIRST = 7'd1;
  localparam logic [FIELD_W-1:0] MONTH_MARCH = 7'd3;
  localparam logic [FIELD_W-1:0] MONTH_LAST  = 7'd12;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;

  localparam logic [SPAN_W-1:0] DAYS_PER_YEAR = 23'd365;
  localparam logic [6:0]        CENTURY       = 7'd100;

  // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for all y up to MAX_YEAR
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    FIELD_YEAR  = 2'd0,
    FIELD_MONTH = 2'd1,
    FIELD_DAY   = 2'd2
  } field_t;

  // days in the months before the given one, non-leap year
  function automatic logic [DBM_W-1:0] days_before_month(input logic [FIELD_W-1:0] month);
    logic [DBM_W-1:0] days;
    case (month)
      7'd1:    days = 9'd0;
      7'd2:    days = 9'd31;
      7'd3:    days = 9'd59;
      7'd4:    days = 9'd90;
      7'd5:    days = 9'd120;
      7'd6:    days = 9'd151;
      7'd7:    days = 9'd181;
      7'd8:    days = 9'd212;
      7'd9:    days = 9'd243;
      7'd10:   days = 9'd273;
      7'd11:   days = 9'd304;
      7'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

/* hw/rtl/date_span_day_counter_top.sv */
// date span day counter: date string parser and day ordinal pipeline
// last char of second date to out_valid: snapshot, multiply, ordinal, output registers
// throughput: one character per cycle; input stalls only when all ordinal stages are held
// behind a waiting result
// reset: synchronous, clears parser state and all stage valid bits, no result pending
module date_span_day_counter_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       char_code,
  input  logic                             end_of_date,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [dsd_pkg::SPAN_W-1:0] day_span,
  output logic                             format_error
);

  // parser state
  logic                          second_active;
  dsd_pkg::field_t               pos;
  logic [dsd_pkg::YEAR_W-1:0]    year_acc;
  logic [dsd_pkg::FIELD_W-1:0]   month_acc;
  logic [dsd_pkg::FIELD_W-1:0]   day_acc;
  logic                          error_seen;

  dsd_pkg::field_t               pos_next;
  logic [dsd_pkg::YEAR_W-1:0]    year_next;
  logic [dsd_pkg::FIELD_W-1:0]   month_next;
  logic [dsd_pkg::FIELD_W-1:0]   day_next;
  logic                          error_next;
  logic                          date_err;
  logic                          is_digit;
  logic [3:0]                    digit;
  logic [16:0]                   year_sum;
  logic [9:0]                    month_sum;
  logic [9:0]                    day_sum;
  logic                          accept;

  // snapshot stage
  logic                          b_valid;
  logic                          b_second;
  logic                          b_err;
  logic [dsd_pkg::YEAR_W-1:0]    b_year;
  logic [dsd_pkg::FIELD_W-1:0]   b_month;
  logic [dsd_pkg::FIELD_W-1:0]   b_day;

  // multiply stage
  logic                          m_valid;
  logic                          m_second;
  logic                          m_err;
  logic [dsd_pkg::YEAR_W-1:0]    m_year;
  logic [dsd_pkg::FIELD_W-1:0]   m_month;
  logic [dsd_pkg::FIELD_W-1:0]   m_day;
  logic [dsd_pkg::SPAN_W-1:0]    m_y365;
  logic [dsd_pkg::Q100_W-1:0]    m_q100;
  logic [26:0]                   q_prod;

  // ordinal stage
  logic                          c_valid;
  logic                          c_second;
  logic                          c_err;
  logic [dsd_pkg::SPAN_W-1:0]    c_ord;
  logic [dsd_pkg::SPAN_W-1:0]    first_ord;
  logic [dsd_pkg::YEAR_W-1:0]    r100;
  logic                          r100_nz;
  logic                          leap;
  logic                          month_ok;
  logic                          leap_add;
  logic [dsd_pkg::SPAN_W-1:0]    ord_next;
  logic [dsd_pkg::SPAN_W-1:0]    span_next;

  // output stage
  logic                          o_valid;
  logic                          o_free;
  logic                          c_move;
  logic                          c_ready;
  logic                          m_ready;
  logic                          b_ready;

  assign o_free  = !o_valid || !out_stall;
  assign c_move  = c_valid && (!c_second || o_free);
  assign c_ready = !c_valid || c_move;
  assign m_ready = !m_valid || c_ready;
  assign b_ready = !b_valid || m_ready;

  assign in_stall  = !b_ready;
  assign accept    = in_valid && !in_stall;
  assign out_valid = o_valid;

  // character parse
  always_comb begin
    is_digit   = (char_code >= dsd_pkg::CHAR_ZERO) && (char_code <= dsd_pkg::CHAR_NINE);
    digit      = char_code[3:0];
    year_sum   = {3'b0, year_acc} * 17'd10 + {13'b0, digit};
    month_sum  = {3'b0, month_acc} * 10'd10 + {6'b0, digit};
    day_sum    = {3'b0, day_acc} * 10'd10 + {6'b0, digit};
    pos_next   = pos;
    year_next  = year_acc;
    month_next = month_acc;
    day_next   = day_acc;
    error_next = error_seen;
    if (is_digit) begin
      case (pos)
        dsd_pkg::FIELD_YEAR: begin
          if (year_sum > {3'b0, dsd_pkg::MAX_YEAR}) begin
            year_next  = dsd_pkg::MAX_YEAR;
            error_next = 1'b1;
          end else begin
            year_next = year_sum[dsd_pkg::YEAR_W-1:0];
          end
        end
        dsd_pkg::FIELD_MONTH: begin
          if (month_sum > {3'b0, dsd_pkg::FIELD_LIMIT}) begin
            month_next = dsd_pkg::FIELD_LIMIT;
            error_next = 1'b1;
          end else begin
            month_next = month_sum[dsd_pkg::FIELD_W-1:0];
          end
        end
        default: begin
          if (day_sum > {3'b0, dsd_pkg::FIELD_LIMIT}) begin
            day_next   = dsd_pkg::FIELD_LIMIT;
            error_next = 1'b1;
          end else begin
            day_next = day_sum[dsd_pkg::FIELD_W-1:0];
          end
        end
      endcase
    end else if (char_code == dsd_pkg::CHAR_SLASH) begin
      case (pos)
        dsd_pkg::FIELD_YEAR:  pos_next = dsd_pkg::FIELD_MONTH;
        dsd_pkg::FIELD_MONTH: pos_next = dsd_pkg::FIELD_DAY;
        default:              error_next = 1'b1;
      endcase
    end else begin
      error_next = 1'b1;
    end
    date_err = error_next || (pos_next != dsd_pkg::FIELD_DAY) ||
               (month_next < dsd_pkg::MONTH_FIRST) || (month_next > dsd_pkg::MONTH_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_active <= 1'b0;
      pos           <= dsd_pkg::FIELD_YEAR;
      year_acc      <= '0;
      month_acc     <= '0;
      day_acc       <= '0;
      error_seen    <= 1'b0;
    end else if (accept) begin
      if (end_of_date) begin
        pos           <= dsd_pkg::FIELD_YEAR;
        year_acc      <= '0;
        month_acc     <= '0;
        day_acc       <= '0;
        second_active <= !second_active;
        error_seen    <= second_active ? 1'b0 : date_err;
      end else begin
        pos        <= pos_next;
        year_acc   <= year_next;
        month_acc  <= month_next;
        day_acc    <= day_next;
        error_seen <= error_next;
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      m_valid <= 1'b0;
      c_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid <= accept && end_of_date;
      end
      if (m_ready) begin
        m_valid <= b_valid;
      end
      if (c_ready) begin
        c_valid <= m_valid;
      end
      if (o_free) begin
        o_valid <= c_move && c_second;
      end
    end
  end

  // snapshot of a closed date
  always_ff @(posedge clk) begin
    if (accept && end_of_date) begin
      b_second <= second_active;
      b_err    <= date_err;
      b_year   <= year_next;
      b_month  <= month_next;
      b_day    <= day_next;
    end
  end

  assign q_prod = {13'b0, b_year} * {14'b0, dsd_pkg::RECIP_100};

  always_ff @(posedge clk) begin
    if (m_ready && b_valid) begin
      m_second <= b_second;
      m_err    <= b_err;
      m_year   <= b_year;
      m_month  <= b_month;
      m_day    <= b_day;
      m_y365   <= {9'b0, b_year} * dsd_pkg::DAYS_PER_YEAR;
      m_q100   <= q_prod[dsd_pkg::RECIP_SHIFT +: dsd_pkg::Q100_W];
    end
  end

  // day ordinal from the year products
  always_comb begin
    r100     = m_year - ({7'b0, m_q100} * {7'b0, dsd_pkg::CENTURY});
    r100_nz  = (r100 != '0);
    leap     = ((m_year[1:0] == 2'b00) && r100_nz) || (!r100_nz && (m_q100[1:0] == 2'b00));
    month_ok = (m_month >= dsd_pkg::MONTH_FIRST) && (m_month <= dsd_pkg::MONTH_LAST);
    leap_add = leap && month_ok && (m_month >= dsd_pkg::MONTH_MARCH);
    ord_next = m_y365
             + 23'(m_year[dsd_pkg::YEAR_W-1:2]) + 23'(m_year[1:0] != 2'b00)
             - 23'(m_q100) - 23'(r100_nz)
             + 23'(m_q100[dsd_pkg::Q100_W-1:2]) + 23'(r100_nz || (m_q100[1:0] != 2'b00))
             + 23'(dsd_pkg::days_before_month(m_month))
             + 23'(leap_add)
             + 23'(m_day);
  end

  always_ff @(posedge clk) begin
    if (c_ready && m_valid) begin
      c_second <= m_second;
      c_err    <= m_err;
      c_ord    <= ord_next;
    end
  end

  always_ff @(posedge clk) begin
    if (c_move && !c_second) begin
      first_ord <= c_ord;
    end
  end

  assign span_next = c_ord - first_ord + 23'd1;

  always_ff @(posedge clk) begin
    if (c_move && c_second) begin
      day_span     <= c_err ? '0 : span_next;
      format_error <= c_err;
    end
  end

  a_year_in_range: assert property (@(posedge clk) disable iff (rst)
    year_acc <= dsd_pkg::MAX_YEAR)
    else $error("year accumulator above limit");

  a_close_snapshots: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_date) |=> b_valid)
    else $error("closed date not captured");

  a_second_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_date && second_active) |=> (!second_active && !error_seen))
    else $error("parser not cleared after second date");

  a_first_keeps_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_date && !second_active) |=>
      (second_active && (pos == dsd_pkg::FIELD_YEAR) && (year_acc == '0)))
    else $error("fields not cleared after first date");

  a_held_second: assert property (@(posedge clk) disable iff (rst)
    (c_valid && c_second && !o_free) |=> c_valid)
    else $error("second ordinal lost while result waits");

  a_error_zero_span: assert property (@(posedge clk) disable iff (rst)
    (o_valid && format_error) |-> (day_span == '0))
    else $error("error result carries a span");

endmodule

/* bench/tb_top.sv */
// testbench for date_span_day_counter_top: streams date pairs and checks day spans and errors
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsd_pkg::*;

  localparam int unsigned CHAR_TARGET  = 1650;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam int unsigned MONTH_OFFSET [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                                304, 334};
  localparam int unsigned LANDMARK_YEARS [9] = '{0, 4, 100, 400, 1900, 2000, 2100, 9996, 9999};

  typedef struct packed {
    logic signed [SPAN_W-1:0] span;
    logic                     err;
  } span_result_t;

  typedef struct {
    string first_text;
    string second_text;
    bit    typed;
    bit    err;
    int    span;
  } date_pair_row_t;

  logic                     clk;
  logic                     rst         = 1'b1;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic [7:0]               char_code   = 8'h00;
  logic                     end_of_date = 1'b0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic signed [SPAN_W-1:0] day_span;
  logic                     format_error;

  date_span_day_counter_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .end_of_date  (end_of_date),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .day_span     (day_span),
    .format_error (format_error)
  );

  // date parser model state
  logic               second_date_open;
  field_t             field_pos;
  logic [YEAR_W-1:0]  year_acc;
  logic [FIELD_W-1:0] month_acc;
  logic [FIELD_W-1:0] day_acc;
  logic [SPAN_W-1:0]  first_ordinal;
  logic               date_fault;

  span_result_t   pending_spans [$];
  logic [7:0]     date_bytes [$];
  int unsigned    chars_sent;
  int unsigned    burst_left;
  int unsigned    mismatch_count;
  bit             random_phase;

  // tilde stands for a nul byte, caret for 8'hff
  date_pair_row_t directed_rows [10] = '{
    '{"/1/1", "/1/1", 1'b1, 1'b0, 1},
    '{"9999/12/31", "/1/1", 1'b1, 1'b0, -3652423},
    '{"~", "^", 1'b1, 1'b1, 0},
    '{"10000//", "//100", 1'b1, 1'b1, 0},
    '{"///", "/", 1'b1, 1'b1, 0},
    '{"/13/", "/0/", 1'b1, 1'b1, 0},
    '{"/2/28", "/3/1", 1'b1, 1'b0, 3},
    '{"100/2/28", "100/3/1", 1'b1, 1'b0, 2},
    '{"0/12/31", "/1/0", 1'b0, 1'b0, 0},
    '{"2024/07/04", "1969/7/20", 1'b0, 1'b0, 0}
  };

  function automatic void clear_fields();
    field_pos = FIELD_YEAR;
    year_acc  = '0;
    month_acc = '0;
    day_acc   = '0;
  endfunction

  function automatic void clear_parser();
    clear_fields();
    second_date_open = 1'b0;
    first_ordinal    = '0;
    date_fault       = 1'b0;
  endfunction

  function automatic int unsigned accumulate_digit(input int unsigned acc, input int unsigned digit,
                                                   input int unsigned limit);
    int unsigned v;
    v = acc * 10 + digit;
    if (v > limit) begin
      date_fault = 1'b1;
      return limit;
    end
    return v;
  endfunction

  function automatic logic [SPAN_W-1:0] close_date();
    int unsigned y;
    int unsigned m;
    int unsigned ord;
    y = 32'(year_acc);
    m = 32'(month_acc);
    ord = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    if (field_pos != FIELD_DAY) date_fault = 1'b1;
    if (m >= 1 && m <= 12) begin
      ord += MONTH_OFFSET[m];
      if (m > 2 && (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0))) ord += 1;
    end else begin
      date_fault = 1'b1;
    end
    ord += 32'(day_acc);
    return ord[SPAN_W-1:0];
  endfunction

  function automatic bit parse_date_char(input logic [7:0] c, input logic eod,
                                         output span_result_t res);
    logic [SPAN_W-1:0] ord;
    int unsigned       digit_val;
    res = '0;
    digit_val = 32'(c - CHAR_ZERO);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      case (field_pos)
        FIELD_YEAR:  year_acc  = YEAR_W'(accumulate_digit(32'(year_acc), digit_val,
                                                          32'(MAX_YEAR)));
        FIELD_MONTH: month_acc = FIELD_W'(accumulate_digit(32'(month_acc), digit_val,
                                                           32'(FIELD_LIMIT)));
        default:     day_acc   = FIELD_W'(accumulate_digit(32'(day_acc), digit_val,
                                                           32'(FIELD_LIMIT)));
      endcase
    end else if (c == CHAR_SLASH) begin
      case (field_pos)
        FIELD_YEAR:  field_pos = FIELD_MONTH;
        FIELD_MONTH: field_pos = FIELD_DAY;
        default:     date_fault = 1'b1;
      endcase
    end else begin
      date_fault = 1'b1;
    end
    if (!eod) return 1'b0;
    ord = close_date();
    if (!second_date_open) begin
      first_ordinal    = ord;
      second_date_open = 1'b1;
      clear_fields();
      return 1'b0;
    end
    res.err  = date_fault;
    res.span = date_fault ? '0 : ord - first_ordinal + 1'b1;
    clear_parser();
    return 1'b1;
  endfunction

  function automatic void append_field(input int unsigned v);
    string digits;
    if (v == 0 && $urandom_range(0, 1) == 0) return;
    if ($urandom_range(0, 7) == 0) date_bytes.push_back(CHAR_ZERO);
    digits = $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++) date_bytes.push_back(digits[i]);
  endfunction

  function automatic void compose_date();
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned spot;
    date_bytes.delete();
    case ($urandom_range(0, 9))
      0:       yr = LANDMARK_YEARS[$urandom_range(0, 8)];
      1:       yr = $urandom_range(0, 9999);
      default: yr = $urandom_range(1800, 2200);
    endcase
    mo = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    dy = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
    append_field(yr);
    date_bytes.push_back(CHAR_SLASH);
    append_field(mo);
    date_bytes.push_back(CHAR_SLASH);
    append_field(dy);
    // broken dates
    if ($urandom_range(0, 6) == 0) begin
      spot = $urandom_range(0, date_bytes.size());
      case ($urandom_range(0, 4))
        0: date_bytes.insert(spot, 8'($urandom_range(0, 255)));
        1: if (spot < date_bytes.size()) date_bytes.delete(spot);
        2: date_bytes.insert(spot, CHAR_SLASH);
        3: repeat ($urandom_range(1, 3))
             date_bytes.insert(spot, CHAR_ZERO + 8'($urandom_range(1, 9)));
        default: begin
          date_bytes.delete();
          repeat ($urandom_range(1, 6)) date_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      if (date_bytes.size() == 0) date_bytes.push_back(CHAR_SLASH);
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eod, output bit got_span);
    span_result_t res;
    int unsigned  gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    char_code   <= c;
    end_of_date <= eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    got_span = parse_date_char(c, eod, res);
    if (got_span) pending_spans.push_back(res);
  endtask

  function automatic void flag_mismatch(input string what, input int expv, input int gotv);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", what, expv, gotv);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL date_span_day_counter_top");
    $finish;
  end

  initial begin : receiver
    int unsigned stretch;
    int unsigned pct;
    bit          held_off;
    held_off = 1'b0;
    forever begin
      if (!held_off && random_phase) begin
        // long hold-off so the pipeline backs up into the input
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stretch = $urandom_range(5, 80);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 30;
          2:       pct = 60;
          default: pct = 90;
        endcase
        repeat (stretch) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    span_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_spans.size() == 0) begin
        flag_mismatch("transfer with nothing pending, day_span", 0, $signed(day_span));
      end else begin
        want = pending_spans.pop_front();
        if (day_span !== want.span)
          flag_mismatch("day_span", $signed(want.span), $signed(day_span));
        if (format_error !== want.err)
          flag_mismatch("format_error", want.err, format_error);
      end
    end
  end

  initial begin : stimulus
    string        text;
    logic [7:0]   ch;
    bit           got;
    span_result_t typed_result;
    clear_parser();
    chars_sent     = 0;
    burst_left     = 0;
    mismatch_count = 0;
    random_phase   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      got = 1'b0;
      for (int half = 0; half < 2; half++) begin
        text = (half == 0) ? directed_rows[r].first_text : directed_rows[r].second_text;
        for (int i = 0; i < text.len(); i++) begin
          ch = text[i];
          if (ch == "~") ch = 8'h00;
          else if (ch == "^") ch = 8'hff;
          send_char(ch, i == text.len() - 1, got);
        end
      end
      if (directed_rows[r].typed && got) begin
        typed_result.span = SPAN_W'(directed_rows[r].span);
        typed_result.err  = directed_rows[r].err;
        pending_spans[pending_spans.size() - 1] = typed_result;
      end
    end

    random_phase = 1'b1;
    while (chars_sent < CHAR_TARGET) begin
      compose_date();
      foreach (date_bytes[k]) send_char(date_bytes[k], k == date_bytes.size() - 1, got);
    end
    in_valid <= 1'b0;

    while (pending_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_spans.size() == 0) begin
      $display("PASS date_span_day_counter_top");
    end else begin
      $display("FAIL date_span_day_counter_top");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/dsd_pkg.sv
hw/rtl/date_span_day_counter_top.sv
bench/tb_top.sv
